[src/aes_rst_pkg.sv]
// ----------------------------------------------------------------------------
// aes_rst_pkg
// Shared types, request codes, S-box table and GF(2^8) helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_rst_pkg;

	typedef logic [7:0] aes_byte_t;
	typedef aes_byte_t [0:15] aes_state_t;

	typedef enum logic [1:0] {
		REQ_SUB_BYTES   = 2'd0,
		REQ_SHIFT_ROWS  = 2'd1,
		REQ_MIX_COLUMNS = 2'd2
	} req_type_t;

	localparam aes_byte_t SBOX [0:255] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam aes_byte_t GF_POLY = 8'h1b;

	function automatic aes_byte_t gf_dbl(input aes_byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic aes_byte_t gf_tpl(input aes_byte_t a);
		return gf_dbl(a) ^ a;
	endfunction

endpackage

`default_nettype wire

[src/aes_rst_xform.sv]
// ----------------------------------------------------------------------------
// aes_rst_xform
// Byte-parallel SubBytes, ShiftRows and MixColumns, or pass-through, with a result select.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_rst_xform
	import aes_rst_pkg::*;
(
	input  wire logic [1:0]   req_type,
	input  wire aes_state_t   state_in,
	output aes_state_t        state_out
);

	aes_state_t sub_st;
	aes_state_t shift_st;
	aes_state_t mix_st;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			sub_st[i] = SBOX[state_in[i]];
		end
	end

	// row r of column c takes row r of column c+r
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				shift_st[c * 4 + r] = state_in[((c + r) & 3) * 4 + r];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				mix_st[c * 4 + r] = gf_dbl(state_in[c * 4 + r])
					^ gf_tpl(state_in[c * 4 + ((r + 1) & 3)])
					^ state_in[c * 4 + ((r + 2) & 3)]
					^ state_in[c * 4 + ((r + 3) & 3)];
			end
		end
	end

	always_comb begin
		unique case (req_type_t'(req_type))
			REQ_SUB_BYTES:   state_out = sub_st;
			REQ_SHIFT_ROWS:  state_out = shift_st;
			REQ_MIX_COLUMNS: state_out = mix_st;
			default:         state_out = state_in;
		endcase
	end

endmodule

`default_nettype wire

[src/aes_round_state_transforms.sv]
// ----------------------------------------------------------------------------
// aes_round_state_transforms
// Each request passes the input register and then the result register before out_valid rises.
// Throughput: one request per cycle while out_ready does not stall the result register.
// Reset clears only the valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round_state_transforms
	import aes_rst_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [63:0] state_hi,
	input  wire logic [63:0] state_lo,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      result_hi,
	output logic [63:0]      result_lo
);

	logic        valid_s1;
	logic [1:0]  type_s1;
	aes_state_t  state_s1;
	logic        valid_s2;
	aes_state_t  res_s2;
	aes_state_t  xform_st;
	logic        adv_s2;
	logic        adv_s1;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = adv_s2;
	assign in_ready = !valid_s1 || adv_s1;

	aes_rst_xform u_xform (
		.req_type  (type_s1),
		.state_in  (state_s1),
		.state_out (xform_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			type_s1  <= req_type;
			state_s1 <= aes_state_t'({state_hi, state_lo});
		end
		if (valid_s1 && adv_s2) begin
			res_s2 <= xform_st;
		end
	end

	assign out_valid = valid_s2;
	assign result_hi = res_s2[0:7];
	assign result_lo = res_s2[8:15];

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for aes_round_state_transforms. Requests carry a
// transform select and a 128-bit state. Each accepted request is predicted
// with an S-box derived from GF(2^8) inversion and the affine map, a row
// rotation and a column mix. Results are matched in order against the
// predictions. Directed corner states come first, then random traffic in
// phases with and without sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import aes_rst_pkg::*;

	localparam logic [1:0] REQ_PASS_THROUGH = 2'd3;
	localparam int CLK_PERIOD = 8;
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_PER_PHASE = 350;
	localparam int REPORT_MAX = 10;
	localparam int NUM_PHASES = 5;
	localparam int SEND_IDLE [0:NUM_PHASES-1] = '{0, 69, 0, 22, 0};
	localparam int RECV_STALL [0:NUM_PHASES-1] = '{0, 0, 69, 22, 0};
	localparam logic [7:0] MIX_ROW [0:3] = '{8'd2, 8'd3, 8'd1, 8'd1};
	localparam logic [127:0] CORNER_STATES [0:4] = '{
		128'h0,
		{128{1'b1}},
		{16{8'h80}},
		128'h193de3bea0f4e22b9ac68d2ae9f84808,
		128'h000102030405060708090a0b0c0d0e0f
	};

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] hi;
		logic [63:0] lo;
	} request_t;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} block_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  req_type;
	logic [63:0] state_hi;
	logic [63:0] state_lo;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_hi;
	logic [63:0] result_lo;

	request_t   pending_reqs[$];
	block_t     expected_blocks[$];
	request_t   next_req;
	block_t     want;
	logic [7:0] sbox_lut [0:255];
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	bit         in_taken = 1'b0;
	bit         running = 1'b0;
	int         mismatches = 0;
	int         checked = 0;
	int         idle_cycles = 0;
	int         op_count [0:3] = '{default: 0};

	aes_round_state_transforms dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.state_hi  (state_hi),
		.state_lo  (state_lo),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_hi (result_hi),
		.result_lo (result_lo)
	);

	function automatic logic [7:0] galois_mult(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic block_t round_transform(input logic [1:0] op, input logic [63:0] hi,
		input logic [63:0] lo);
		logic [7:0] src [0:15];
		logic [7:0] dst [0:15];
		logic [7:0] acc;
		block_t     res;
		for (int i = 0; i < 8; i++) begin
			src[i]     = hi[63 - 8 * i -: 8];
			src[i + 8] = lo[63 - 8 * i -: 8];
		end
		dst = src;
		case (op)
			REQ_SUB_BYTES: begin
				for (int i = 0; i < 16; i++)
					dst[i] = sbox_lut[src[i]];
			end
			REQ_SHIFT_ROWS: begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						dst[c * 4 + r] = src[((c + r) & 3) * 4 + r];
			end
			REQ_MIX_COLUMNS: begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++) begin
						acc = 8'h00;
						for (int k = 0; k < 4; k++)
							acc ^= galois_mult(src[c * 4 + k], MIX_ROW[(k - r) & 3]);
						dst[c * 4 + r] = acc;
					end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < 8; i++) begin
			res.hi[63 - 8 * i -: 8] = dst[i];
			res.lo[63 - 8 * i -: 8] = dst[i + 8];
		end
		return res;
	endfunction

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// request driver and result back-pressure
	always @(negedge clk) begin
		out_ready <= running && ($urandom_range(99) >= recv_stall_pct);
		if (!in_valid || in_taken) begin
			if (running && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = pending_reqs.pop_front();
				req_type <= next_req.op;
				state_hi <= next_req.hi;
				state_lo <= next_req.lo;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// prediction, result check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken = in_valid && in_ready;
			if (in_taken) begin
				expected_blocks.push_back(round_transform(req_type, state_hi, state_lo));
				op_count[req_type]++;
			end
			if (out_valid && out_ready) begin
				if (expected_blocks.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("tb_top: result %h_%h with no request pending",
							result_hi, result_lo);
					mismatches++;
				end else begin
					want = expected_blocks.pop_front();
					checked++;
					if (result_hi !== want.hi || result_lo !== want.lo) begin
						if (mismatches < REPORT_MAX)
							$display("tb_top: result %0d hi exp %h got %h, lo exp %h got %h",
								checked, want.hi, result_hi, want.lo, result_lo);
						mismatches++;
					end
				end
			end
			if (in_taken || (out_valid && out_ready))
				idle_cycles = 0;
			else if (running)
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_top: no handshake for %0d cycles", STALL_LIMIT);
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0]   inv;
		logic [7:0]   byte_v;
		logic [1:0]   op;
		logic [127:0] rnd;

		// S-box: multiplicative inverse followed by the affine map
		for (int v = 0; v < 256; v++) begin
			inv = 8'h01;
			for (int e = 0; e < 254; e++)
				inv = galois_mult(inv, 8'(v));
			sbox_lut[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end

		in_valid  = 1'b0;
		out_ready = 1'b0;
		req_type  = REQ_SUB_BYTES;
		state_hi  = 64'h0;
		state_lo  = 64'h0;
		arst_n    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			send_idle_pct  = SEND_IDLE[phase];
			recv_stall_pct = RECV_STALL[phase];
			if (phase == 0) begin
				for (int s = 0; s < 5; s++)
					for (int o = REQ_SUB_BYTES; o <= REQ_PASS_THROUGH; o++)
						pending_reqs.push_back('{op: 2'(o), hi: CORNER_STATES[s][127:64],
							lo: CORNER_STATES[s][63:0]});
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if ($urandom_range(9) == 0)
					op = REQ_PASS_THROUGH;
				else
					op = 2'($urandom_range(REQ_MIX_COLUMNS, REQ_SUB_BYTES));
				if ($urandom_range(1)) begin
					rnd = {$urandom, $urandom, $urandom, $urandom};
				end else begin
					for (int b = 0; b < 16; b++) begin
						case ($urandom_range(3))
							0: byte_v = 8'h00;
							1: byte_v = 8'hff;
							2: byte_v = 8'h80;
							default: byte_v = 8'($urandom);
						endcase
						rnd = {rnd[119:0], byte_v};
					end
				end
				pending_reqs.push_back('{op: op, hi: rnd[127:64], lo: rnd[63:0]});
			end
			running = 1'b1;
			// next phase waits until every request is sent and every result has drained
			while (pending_reqs.size() > 0 || in_valid || expected_blocks.size() > 0)
				@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("tb_top: %0d SubBytes, %0d ShiftRows, %0d MixColumns, %0d pass-through requests",
			op_count[REQ_SUB_BYTES], op_count[REQ_SHIFT_ROWS], op_count[REQ_MIX_COLUMNS],
			op_count[REQ_PASS_THROUGH]);
		$display("tb_top: %0d results checked over %0d idle/stall phases, %0d mismatches",
			checked, NUM_PHASES, mismatches);
		if (mismatches == 0 && expected_blocks.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

[files.f]
src/aes_rst_pkg.sv
src/aes_rst_xform.sv
src/aes_round_state_transforms.sv
tb/sv/tb_top.sv
